// File: hw/rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared widths, register indexes, reset values and the control bundle that
// travels from the envelope control to the output merge stage.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SampleBits     = 16;
  localparam int CountBits      = 16;
  localparam int FramesLeftBits = 24;
  localparam int CfgIdxBits     = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MONO_MODE = 2'd0,
    CFG_FADE_IN   = 2'd1,
    CFG_FADE_OUT  = 2'd2,
    CFG_PAD       = 2'd3
  } cfg_idx_e;

  localparam int FadeInReset  = 4410;
  localparam int FadeOutReset = 4410;
  localparam int PadReset     = 8820;

  typedef struct packed {
    logic silent;
    logic active;
    logic finished;
  } merge_ctrl_t;

endpackage

// File: hw/rtl/pfe_if.sv
// ----------------------------------------------------------------------------
// pfe_if
// Valid/ready stream interfaces for frame slots in and faded frames out.
// ----------------------------------------------------------------------------
interface pfe_in_if #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits
);
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic                                have_frame;
  logic signed [SAMPLE_BITS-1:0]       left_in;
  logic signed [SAMPLE_BITS-1:0]       right_in;
  logic [pfe_pkg::FramesLeftBits-1:0]  frames_left;

  modport source (
    output valid, start_req, have_frame, left_in, right_in, frames_left,
    input  ready
  );
  modport sink (
    input  valid, start_req, have_frame, left_in, right_in, frames_left,
    output ready
  );
endinterface

interface pfe_out_if #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          active;
  logic                          finished;

  modport source (
    output valid, left_out, right_out, active, finished,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, active, finished,
    output ready
  );
endinterface

// File: hw/rtl/pfe_lane.sv
// ----------------------------------------------------------------------------
// pfe_lane
// One channel gain lane: sample * num / den, truncated toward zero.
// Multiplies once, then runs a restoring divider one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_lane #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits,
  parameter int COUNT_BITS  = pfe_pkg::CountBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [COUNT_BITS-1:0]         num_i,
  input  logic [COUNT_BITS-1:0]         den_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int ProdBits = SAMPLE_BITS + COUNT_BITS;
  localparam int StepBits = $clog2(SAMPLE_BITS);
  localparam logic [StepBits-1:0] StepLast = StepBits'(SAMPLE_BITS - 1);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_MUL  = 3'b010,
    L_DIV  = 3'b100
  } lane_state_e;

  lane_state_e              state_q, state_d;
  logic [StepBits-1:0]      step_q, step_d;
  logic                     done_q, done_d;
  logic [SAMPLE_BITS-1:0]   mag_q;
  logic [COUNT_BITS-1:0]    num_q;
  logic [COUNT_BITS-1:0]    den_q;
  logic                     neg_q;
  logic [ProdBits:0]        div_q, div_d;

  logic [SAMPLE_BITS-1:0]   mag_in;
  logic [ProdBits-1:0]      prod;
  logic [COUNT_BITS:0]      shifted;
  logic [COUNT_BITS:0]      rem_next;
  logic                     ge;
  logic [SAMPLE_BITS-1:0]   quo;

  assign mag_in = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
  assign prod   = ProdBits'(mag_q) * ProdBits'(num_q);

  // remainder stays below den, so one extra bit holds the shifted value
  assign shifted  = {div_q[ProdBits-1:SAMPLE_BITS], div_q[SAMPLE_BITS-1]};
  assign ge       = (shifted >= {1'b0, den_q});
  assign rem_next = ge ? (shifted - {1'b0, den_q}) : shifted;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    div_d   = div_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        div_d   = {1'b0, prod};
        step_d  = '0;
        state_d = L_DIV;
      end
      L_DIV: begin
        div_d  = {rem_next, div_q[SAMPLE_BITS-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == StepLast) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      mag_q <= mag_in;
      num_q <= num_i;
      den_q <= den_i;
      neg_q <= sample_i[SAMPLE_BITS-1];
    end
    div_q <= div_d;
  end

  assign quo      = div_q[SAMPLE_BITS-1:0];
  assign done_o   = done_q;
  assign result_o = neg_q ? signed'(~quo + 1'b1) : signed'(quo);

endmodule

// File: hw/rtl/pfe_merge.sv
// ----------------------------------------------------------------------------
// pfe_merge
// Merges the two lane results with the frame flags into the output register.
// Silent frames are forced to zero here.
// ----------------------------------------------------------------------------
module pfe_merge #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  pfe_pkg::merge_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  pfe_out_if.source                     out_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          active_q;
  logic                          finished_q;
  logic                          load;

  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q     <= ctrl_i.silent ? '0 : left_i;
      right_q    <= ctrl_i.silent ? '0 : right_i;
      active_q   <= ctrl_i.active;
      finished_q <= ctrl_i.finished;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.left_out  = left_q;
  assign out_o.right_out = right_q;
  assign out_o.active    = active_q;
  assign out_o.finished  = finished_q;

endmodule

// File: hw/rtl/pcm_fade_envelope.sv
// ----------------------------------------------------------------------------
// pcm_fade_envelope
// Linear fade-in / fade-out envelope with end-of-file silence padding.
// ----------------------------------------------------------------------------
// Usage: in_i carries one frame slot per item (start flag, frame-present flag,
// left/right samples, frames remaining); out_o gives one faded frame per item
// with active and finished flags. The user must write registers via cfg_we_i,
// cfg_idx_i and cfg_data_i only while no item is in flight (not enforced).
// Two gain lanes (left, right) run side by side; each gain is one multiply
// and a restoring divide that yields one quotient bit per cycle.
// One item at a time. A frame that needs no gain goes from the input straight
// to the merge state and the output register; each gain pass runs both lanes'
// multiply and divide, and a frame under both fade-in and fade-out takes both.
// The divider step loop sets the rate.
// The output register lets the next item be taken and worked on while the
// previous result waits; a stalled receiver holds the merge state until the
// register frees.
// Reset clears the envelope (not playing) and loads the register defaults.
// ----------------------------------------------------------------------------
module pcm_fade_envelope #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits,
  parameter int COUNT_BITS  = pfe_pkg::CountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfe_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [COUNT_BITS-1:0]          cfg_data_i,
  pfe_in_if.sink                         in_i,
  pfe_out_if.source                      out_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_IN    = 4'b0010,
    S_OUT   = 4'b0100,
    S_MERGE = 4'b1000
  } state_e;

  // configuration
  logic                  mono_q;
  logic [COUNT_BITS-1:0] fi_len_q;
  logic [COUNT_BITS-1:0] fo_len_q;
  logic [COUNT_BITS-1:0] pad_len_q;

  // envelope state
  logic                  playing_q, playing_d;
  logic                  fi_on_q, fi_on_d;
  logic [COUNT_BITS-1:0] fi_cnt_q, fi_cnt_d;
  logic                  fo_on_q, fo_on_d;
  logic [COUNT_BITS-1:0] fo_cnt_q, fo_cnt_d;
  logic                  pad_on_q, pad_on_d;
  logic [COUNT_BITS-1:0] pad_cnt_q, pad_cnt_d;

  // per-item job
  state_e                        state_q, state_d;
  pfe_pkg::merge_ctrl_t          ctrl_d, ctrl_q;
  logic                          do_in, do_out;
  logic [COUNT_BITS-1:0]         in_num, out_num;
  logic                          job_do_out_q;
  logic [COUNT_BITS-1:0]         job_out_num_q;
  logic signed [SAMPLE_BITS-1:0] r_src;
  logic signed [SAMPLE_BITS-1:0] smp_l_q, smp_r_q;
  logic                          in_acc;

  // lanes
  logic                          lane_start;
  logic signed [SAMPLE_BITS-1:0] lane_l, lane_r;
  logic [COUNT_BITS-1:0]         lane_num, lane_den;
  logic                          done_l, done_r, lanes_done;
  logic signed [SAMPLE_BITS-1:0] res_l, res_r;
  logic                          merge_ready;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign lanes_done = done_l && done_r;
  assign r_src      = mono_q ? in_i.left_in : in_i.right_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q    <= 1'b0;
      fi_len_q  <= COUNT_BITS'(pfe_pkg::FadeInReset);
      fo_len_q  <= COUNT_BITS'(pfe_pkg::FadeOutReset);
      pad_len_q <= COUNT_BITS'(pfe_pkg::PadReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfe_pkg::CFG_MONO_MODE: mono_q    <= cfg_data_i[0];
        pfe_pkg::CFG_FADE_IN:   fi_len_q  <= cfg_data_i;
        pfe_pkg::CFG_FADE_OUT:  fo_len_q  <= cfg_data_i;
        pfe_pkg::CFG_PAD:       pad_len_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // envelope update for the item on the input
  always_comb begin
    playing_d = playing_q;
    fi_on_d   = fi_on_q;
    fi_cnt_d  = fi_cnt_q;
    fo_on_d   = fo_on_q;
    fo_cnt_d  = fo_cnt_q;
    pad_on_d  = pad_on_q;
    pad_cnt_d = pad_cnt_q;
    ctrl_d    = '{silent: 1'b1, active: 1'b0, finished: 1'b0};
    do_in     = 1'b0;
    do_out    = 1'b0;
    in_num    = '0;
    out_num   = '0;

    if (in_i.start_req) begin
      playing_d = 1'b1;
      fi_on_d   = 1'b1;
      fi_cnt_d  = '0;
      fo_on_d   = 1'b0;
      fo_cnt_d  = '0;
      pad_on_d  = 1'b0;
      pad_cnt_d = '0;
    end

    if (playing_d) begin
      ctrl_d.active = 1'b1;
      if (pad_on_d) begin
        if (pad_cnt_d >= pad_len_q) begin
          playing_d       = 1'b0;
          pad_on_d        = 1'b0;
          pad_cnt_d       = '0;
          ctrl_d.finished = 1'b1;
        end else if (pad_cnt_d != CountMax) begin
          pad_cnt_d = pad_cnt_d + 1'b1;
        end
      end else begin
        if (!fo_on_d && (in_i.frames_left != '0)
            && (in_i.frames_left <= pfe_pkg::FramesLeftBits'(fo_len_q))) begin
          fo_on_d  = 1'b1;
          fo_cnt_d = '0;
        end
        if (!in_i.have_frame) begin
          pad_on_d  = 1'b1;
          pad_cnt_d = COUNT_BITS'(1);
        end else begin
          ctrl_d.silent = 1'b0;
          if (fi_on_d) begin
            if (fi_cnt_d >= fi_len_q) begin
              fi_on_d = 1'b0;
            end else begin
              do_in  = 1'b1;
              in_num = fi_cnt_d;
              if (fi_cnt_d != CountMax) begin
                fi_cnt_d = fi_cnt_d + 1'b1;
              end
            end
          end
          if (fo_on_d) begin
            if (fo_cnt_d >= fo_len_q) begin
              // gain is zero: skip both passes
              ctrl_d.silent = 1'b1;
              do_in         = 1'b0;
            end else begin
              do_out  = 1'b1;
              out_num = fo_len_q - fo_cnt_d;
            end
            if (fo_cnt_d != CountMax) begin
              fo_cnt_d = fo_cnt_d + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      fi_on_q   <= 1'b0;
      fi_cnt_q  <= '0;
      fo_on_q   <= 1'b0;
      fo_cnt_q  <= '0;
      pad_on_q  <= 1'b0;
      pad_cnt_q <= '0;
    end else if (in_acc) begin
      playing_q <= playing_d;
      fi_on_q   <= fi_on_d;
      fi_cnt_q  <= fi_cnt_d;
      fo_on_q   <= fo_on_d;
      fo_cnt_q  <= fo_cnt_d;
      pad_on_q  <= pad_on_d;
      pad_cnt_q <= pad_cnt_d;
    end
  end

  // sequencer: optional fade-in pass, optional fade-out pass, then merge
  always_comb begin
    state_d    = state_q;
    lane_start = 1'b0;
    lane_l     = in_i.left_in;
    lane_r     = r_src;
    lane_num   = in_num;
    lane_den   = fi_len_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (do_in) begin
            lane_start = 1'b1;
            state_d    = S_IN;
          end else if (do_out) begin
            lane_start = 1'b1;
            lane_num   = out_num;
            lane_den   = fo_len_q;
            state_d    = S_OUT;
          end else begin
            state_d = S_MERGE;
          end
        end
      end
      S_IN: begin
        if (lanes_done) begin
          if (job_do_out_q) begin
            lane_start = 1'b1;
            lane_l     = res_l;
            lane_r     = res_r;
            lane_num   = job_out_num_q;
            lane_den   = fo_len_q;
            state_d    = S_OUT;
          end else begin
            state_d = S_MERGE;
          end
        end
      end
      S_OUT: begin
        if (lanes_done) begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (merge_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctrl_q        <= ctrl_d;
      job_do_out_q  <= do_out;
      job_out_num_q <= out_num;
      smp_l_q       <= in_i.left_in;
      smp_r_q       <= r_src;
    end else if (lanes_done) begin
      smp_l_q <= res_l;
      smp_r_q <= res_r;
    end
  end

  pfe_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .sample_i (lane_l),
    .num_i    (lane_num),
    .den_i    (lane_den),
    .done_o   (done_l),
    .result_o (res_l)
  );

  pfe_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .sample_i (lane_r),
    .num_i    (lane_num),
    .den_i    (lane_den),
    .done_o   (done_r),
    .result_o (res_r)
  );

  pfe_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == S_MERGE),
    .ready_o (merge_ready),
    .ctrl_i  (ctrl_q),
    .left_i  (smp_l_q),
    .right_i (smp_r_q),
    .out_o   (out_o)
  );

endmodule

// File: hw/rtl/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks for pcm_fade_envelope, attached by bind.
// ----------------------------------------------------------------------------
module pfe_checker #(
  parameter int SAMPLE_BITS = pfe_pkg::SampleBits
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_i,
  input logic signed [SAMPLE_BITS-1:0] right_out_i,
  input logic                          active_i,
  input logic                          finished_i
);

  // one item at a time: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready held after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finished_i |-> active_i)
    else $error("finished item without active");

  // idle or finishing frames carry silence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!active_i || finished_i) |->
      (left_out_i == '0) && (right_out_i == '0))
    else $error("nonzero sample on silent item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_out_i)
      && $stable(right_out_i) && $stable(active_i) && $stable(finished_i))
    else $error("stalled output item changed");

endmodule

bind pcm_fade_envelope pfe_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out),
  .active_i    (out_o.active),
  .finished_i  (out_o.finished)
);
